FILE: rtl/ptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and arithmetic helpers for the pressure and
// temperature compensation core.
// ----------------------------------------------------------------------------
package ptc_pkg;

	localparam int RAW_W       = 20;
	localparam int FIFO_DEPTH  = 4;
	localparam int DIV_W       = 64;

	localparam logic [63:0] FINE_OFFSET  = 64'd128000;
	localparam logic [63:0] P_FULL_SCALE = 64'd1048576;
	localparam logic [63:0] P_SCALE      = 64'd3125;
	localparam logic [31:0] T_ROUND      = 32'd128;
	localparam logic [63:0] V1_BIAS      = 64'h0000_8000_0000_0000;

	typedef enum logic [1:0] {
		CFG_TEMP_CAL       = 2'd0,
		CFG_PRESS_CAL_LOW  = 2'd1,
		CFG_PRESS_CAL_HIGH = 2'd2,
		CFG_PRESS_CAL_LAST = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} coef_t;

	// item handed from the temperature front end to the pressure back end
	typedef struct packed {
		logic [31:0]      temp;
		logic [63:0]      v1;
		logic [RAW_W-1:0] rp;
	} fe_item_t;

	function automatic logic [31:0] sar32(input logic [31:0] x, input int unsigned n);
		logic signed [31:0] s;
		s = $signed(x);
		return 32'(s >>> n);
	endfunction

	function automatic logic [63:0] sar64(input logic [63:0] x, input int unsigned n);
		logic signed [63:0] s;
		s = $signed(x);
		return 64'(s >>> n);
	endfunction

	function automatic logic [31:0] sext16_32(input logic [15:0] c);
		return {{16{c[15]}}, c};
	endfunction

	function automatic logic [63:0] sext16_64(input logic [15:0] c);
		return {{48{c[15]}}, c};
	endfunction

	// low 64 bits of a times a signed 16-bit coefficient
	function automatic logic [63:0] mul_s16(input logic [63:0] a, input logic [15:0] c);
		logic signed [63:0] r;
		r = $signed(a) * $signed(c);
		return 64'(r);
	endfunction

	// low 64 bits of a times an unsigned 16-bit coefficient
	function automatic logic [63:0] mul_u16(input logic [63:0] a, input logic [15:0] c);
		logic [63:0] r;
		r = a * {48'd0, c};
		return r;
	endfunction

endpackage

FILE: rtl/ptc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_front
// Temperature pipeline: fine temperature in 32-bit wrapping arithmetic,
// compensated temperature and the pressure offset term handed to the queue.
// ----------------------------------------------------------------------------
module ptc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ptc_pkg::coef_t               coef,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ptc_pkg::RAW_W-1:0]    raw_temperature,
	input  logic [ptc_pkg::RAW_W-1:0]    raw_pressure,
	input  logic                         q_full,
	output logic                         push,
	output ptc_pkg::fe_item_t            push_item
);
	import ptc_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [RAW_W-1:0] rt_s1;
	logic [RAW_W-1:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5;
	logic [31:0] x1_s2, d_s2;
	logic [31:0] am_s3, dd_s3;
	logic [31:0] a_s4, bm_s4;
	logic [31:0] fine_s5;
	logic [31:0] t1, t2, t3;
	logic [31:0] tm;

	assign t1 = {16'd0, coef.t1};
	assign t2 = sext16_32(coef.t2);
	assign t3 = sext16_32(coef.t3);

	assign en       = !(v_s5 && q_full);
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s1   <= raw_temperature;
			rp_s1   <= raw_pressure;
			x1_s2   <= {15'd0, rt_s1[19:3]} - {t1[30:0], 1'b0};
			d_s2    <= {16'd0, rt_s1[19:4]} - t1;
			rp_s2   <= rp_s1;
			am_s3   <= x1_s2 * t2;
			dd_s3   <= d_s2 * d_s2;
			rp_s3   <= rp_s2;
			a_s4    <= sar32(am_s3, 11);
			bm_s4   <= sar32(dd_s3, 12) * t3;
			rp_s4   <= rp_s3;
			fine_s5 <= a_s4 + sar32(bm_s4, 14);
			rp_s5   <= rp_s4;
		end
	end

	// fine * 5 + 128
	assign tm = {fine_s5[29:0], 2'b00} + fine_s5 + T_ROUND;

	assign push           = v_s5 && !q_full;
	assign push_item.temp = sar32(tm, 8);
	assign push_item.v1   = {{32{fine_s5[31]}}, fine_s5} - FINE_OFFSET;
	assign push_item.rp   = rp_s5;

endmodule

FILE: rtl/ptc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_fifo
// Small register queue between the temperature and pressure pipelines.
// ----------------------------------------------------------------------------
module ptc_fifo #(
	parameter int DEPTH = ptc_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ptc_pkg::fe_item_t push_item,
	input  logic              pop,
	output ptc_pkg::fe_item_t pop_item,
	output logic              full,
	output logic              empty
);
	import ptc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	fe_item_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)      count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: rtl/ptc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined signed divider, truncating toward zero: one quotient bit per
// stage on magnitudes, sign applied by the caller. Side bits ride along.
// ----------------------------------------------------------------------------
module ptc_div #(
	parameter int SW = 33
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [ptc_pkg::DIV_W-1:0]   num,
	input  logic [ptc_pkg::DIV_W-1:0]   den,
	input  logic [SW-1:0]               side_in,
	output logic                        out_valid,
	output logic [ptc_pkg::DIV_W-1:0]   quo_mag,
	output logic                        quo_neg,
	output logic [SW-1:0]               side_out
);
	import ptc_pkg::*;

	localparam int N = DIV_W;

	logic [N-1:0]  rem_s  [N+1];
	logic [N-1:0]  nq_s   [N+1];
	logic [N-1:0]  dm_s   [N+1];
	logic          neg_s  [N+1];
	logic [SW-1:0] side_s [N+1];
	logic          v_s    [N+1];

	// stage 0: magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en)  v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			nq_s[0]   <= num[N-1] ? (N'(0) - num) : num;
			dm_s[0]   <= den[N-1] ? (N'(0) - den) : den;
			neg_s[0]  <= num[N-1] ^ den[N-1];
			side_s[0] <= side_in;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [N-1:0] trial;
		logic         take;

		// remainder stays below a nonzero divisor magnitude, which is at most 2^(N-1)
		assign trial = {rem_s[k][N-2:0], nq_s[k][N-1]};
		assign take  = (trial >= dm_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en)  v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? (trial - dm_s[k]) : trial;
				nq_s[k+1]   <= {nq_s[k][N-2:0], take};
				dm_s[k+1]   <= dm_s[k];
				neg_s[k+1]  <= neg_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[N];
	assign quo_mag   = nq_s[N];
	assign quo_neg   = neg_s[N];
	assign side_out  = side_s[N];

endmodule

FILE: rtl/ptc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_back
// Pressure pipeline: 64-bit polynomial, pipelined division, final
// correction terms and the output register.
// ----------------------------------------------------------------------------
module ptc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ptc_pkg::coef_t    coef,
	input  logic              q_empty,
	output logic              pop,
	input  ptc_pkg::fe_item_t pop_item,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       temperature,
	output logic [31:0]       pressure,
	output logic              divide_by_zero
);
	import ptc_pkg::*;

	localparam int SW = 33;

	logic en;
	logic v_b1, v_b2, v_b3, v_b4, v_b5, v_b6;
	logic v_c1, v_c2, v_c3, v_c4, v_c5;
	logic out_valid_q;

	logic [31:0] temp_b1, temp_b2, temp_b3, temp_b4, temp_b5, temp_b6;
	logic [RAW_W-1:0] rp_b1, rp_b2, rp_b3, rp_b4;
	logic [63:0] pl_b1;
	logic [31:0] ph_b1;
	logic [63:0] m5_b1, m2_b1, m5_b2, m2_b2, m5_b3, m2_b3;
	logic [63:0] sq_b2;
	logic [63:0] v2a_b3, v1a_b3;
	logic [63:0] v2_b4, v1c_b4;
	logic [63:0] v1d_b5, nump_b5;
	logic [63:0] den_b6, num_b6;

	logic          dv_valid, dv_neg;
	logic [63:0]   dv_mag;
	logic [SW-1:0] dv_side;

	logic [31:0] temp_c1, temp_c2, temp_c3, temp_c4, temp_c5;
	logic        dz_c1, dz_c2, dz_c3, dz_c4, dz_c5;
	logic [63:0] p_c1, p_c2, p_c3, p_c4;
	logic [63:0] pl_c2;
	logic [31:0] ph_c2;
	logic [63:0] m8_c2, m8_c3, m8_c4;
	logic [63:0] pp_c3;
	logic [63:0] w1m_c4;
	logic [63:0] sum_c5;

	logic [63:0] ps;
	logic [63:0] res;
	logic [63:0] v1_in;
	logic [63:0] pfs;

	logic [31:0] temperature_q, pressure_q;
	logic        dz_q;

	assign en  = !out_valid_q || out_ready;
	assign pop = en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
			v_b5 <= 1'b0;
			v_b6 <= 1'b0;
			v_c1 <= 1'b0;
			v_c2 <= 1'b0;
			v_c3 <= 1'b0;
			v_c4 <= 1'b0;
			v_c5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_b1 <= !q_empty;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
			v_b5 <= v_b4;
			v_b6 <= v_b5;
			v_c1 <= dv_valid;
			v_c2 <= v_c1;
			v_c3 <= v_c2;
			v_c4 <= v_c3;
			v_c5 <= v_c4;
			out_valid_q <= v_c5;
		end
	end

	assign v1_in = pop_item.v1;
	assign pfs   = P_FULL_SCALE - {44'd0, rp_b4};

	// v1 squared from 32x32 partials; both cross terms are equal
	always_ff @(posedge clk) begin
		if (en) begin
			temp_b1 <= pop_item.temp;
			rp_b1   <= pop_item.rp;
			pl_b1   <= v1_in[31:0] * v1_in[31:0];
			ph_b1   <= 32'(v1_in[63:32] * v1_in[31:0]);
			m5_b1   <= mul_s16(v1_in, coef.p5);
			m2_b1   <= mul_s16(v1_in, coef.p2);

			temp_b2 <= temp_b1;
			rp_b2   <= rp_b1;
			sq_b2   <= pl_b1 + {ph_b1[30:0], 1'b0, 32'd0};
			m5_b2   <= m5_b1;
			m2_b2   <= m2_b1;

			temp_b3 <= temp_b2;
			rp_b3   <= rp_b2;
			v2a_b3  <= mul_s16(sq_b2, coef.p6);
			v1a_b3  <= mul_s16(sq_b2, coef.p3);
			m5_b3   <= m5_b2;
			m2_b3   <= m2_b2;

			temp_b4 <= temp_b3;
			rp_b4   <= rp_b3;
			v2_b4   <= v2a_b3 + {m5_b3[46:0], 17'd0} + {{13{coef.p4[15]}}, coef.p4, 35'd0};
			v1c_b4  <= V1_BIAS + sar64(v1a_b3, 8) + {m2_b3[51:0], 12'd0};

			temp_b5 <= temp_b4;
			v1d_b5  <= mul_u16(v1c_b4, coef.p1);
			nump_b5 <= {pfs[32:0], 31'd0} - v2_b4;

			temp_b6 <= temp_b5;
			den_b6  <= sar64(v1d_b5, 33);
			num_b6  <= nump_b5 * P_SCALE;
		end
	end

	ptc_div #(
		.SW(SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_b6),
		.num      (num_b6),
		.den      (den_b6),
		.side_in  ({den_b6 == 64'd0, temp_b6}),
		.out_valid(dv_valid),
		.quo_mag  (dv_mag),
		.quo_neg  (dv_neg),
		.side_out (dv_side)
	);

	assign ps  = sar64(p_c1, 13);
	assign res = sar64(sum_c5, 8) + {{44{coef.p7[15]}}, coef.p7, 4'd0};

	always_ff @(posedge clk) begin
		if (en) begin
			temp_c1 <= dv_side[31:0];
			dz_c1   <= dv_side[32];
			p_c1    <= dv_neg ? (64'd0 - dv_mag) : dv_mag;

			temp_c2 <= temp_c1;
			dz_c2   <= dz_c1;
			p_c2    <= p_c1;
			pl_c2   <= ps[31:0] * ps[31:0];
			ph_c2   <= 32'(ps[63:32] * ps[31:0]);
			m8_c2   <= mul_s16(p_c1, coef.p8);

			temp_c3 <= temp_c2;
			dz_c3   <= dz_c2;
			p_c3    <= p_c2;
			pp_c3   <= pl_c2 + {ph_c2[30:0], 1'b0, 32'd0};
			m8_c3   <= m8_c2;

			temp_c4 <= temp_c3;
			dz_c4   <= dz_c3;
			p_c4    <= p_c3;
			w1m_c4  <= mul_s16(pp_c3, coef.p9);
			m8_c4   <= m8_c3;

			temp_c5 <= temp_c4;
			dz_c5   <= dz_c4;
			sum_c5  <= p_c4 + sar64(w1m_c4, 25) + sar64(m8_c4, 19);

			temperature_q <= temp_c5;
			pressure_q    <= dz_c5 ? 32'd0 : res[31:0];
			dz_q          <= dz_c5;
		end
	end

	assign out_valid      = out_valid_q;
	assign temperature    = temperature_q;
	assign pressure       = pressure_q;
	assign divide_by_zero = dz_q;

endmodule

FILE: rtl/pressure_temperature_compensation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core
// Barometric sensor compensation: temperature front end, queue, pressure
// back end with pipelined 64-bit signed division.
//
//   channel   direction  content
//   s_*       in         tdata: raw_temperature, raw_pressure
//   m_*       out        tdata: temperature, pressure; tuser: divide_by_zero
//   cfg_*     in         calibration register writes
//
// One beat per cycle in and out while nothing stalls. A beat passes through the
// temperature pipeline, the queue register, the polynomial stages, the divider
// (a magnitude stage, then one quotient bit per stage), the final correction
// stages and the output register. The back end stalls as a whole while an
// output beat waits; the front end keeps running until the 4-entry queue fills.
// Reset clears all pipeline valids and the calibration registers.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_core #(
	parameter int FIFO_DEPTH = ptc_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,    // [19:0] raw_temperature, [39:20] raw_pressure
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // [31:0] temperature, [63:32] pressure
	output logic        m_tuser,    // [0] divide_by_zero
	input  logic        cfg_we,
	input  ptc_pkg::cfg_index_t cfg_index,
	input  logic [63:0] cfg_data
);
	import ptc_pkg::*;

	logic [47:0] temp_cal_q;
	logic [63:0] press_cal_low_q, press_cal_high_q;
	logic [15:0] press_cal_last_q;
	coef_t       coef;

	logic     q_full, q_empty, push, pop;
	fe_item_t push_item, pop_item;
	logic [31:0] temperature, pressure;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q       <= '0;
			press_cal_low_q  <= '0;
			press_cal_high_q <= '0;
			press_cal_last_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEMP_CAL:       temp_cal_q       <= cfg_data[47:0];
				CFG_PRESS_CAL_LOW:  press_cal_low_q  <= cfg_data;
				CFG_PRESS_CAL_HIGH: press_cal_high_q <= cfg_data;
				CFG_PRESS_CAL_LAST: press_cal_last_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign coef.t1 = temp_cal_q[15:0];
	assign coef.t2 = temp_cal_q[31:16];
	assign coef.t3 = temp_cal_q[47:32];
	assign coef.p1 = press_cal_low_q[15:0];
	assign coef.p2 = press_cal_low_q[31:16];
	assign coef.p3 = press_cal_low_q[47:32];
	assign coef.p4 = press_cal_low_q[63:48];
	assign coef.p5 = press_cal_high_q[15:0];
	assign coef.p6 = press_cal_high_q[31:16];
	assign coef.p7 = press_cal_high_q[47:32];
	assign coef.p8 = press_cal_high_q[63:48];
	assign coef.p9 = press_cal_last_q;

	ptc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.coef           (coef),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.raw_temperature(s_tdata[19:0]),
		.raw_pressure   (s_tdata[39:20]),
		.q_full         (q_full),
		.push           (push),
		.push_item      (push_item)
	);

	ptc_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.pop_item (pop_item),
		.full     (q_full),
		.empty    (q_empty)
	);

	ptc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.coef          (coef),
		.q_empty       (q_empty),
		.pop           (pop),
		.pop_item      (pop_item),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.temperature   (temperature),
		.pressure      (pressure),
		.divide_by_zero(m_tuser)
	);

	assign m_tdata = {pressure, temperature};

endmodule
